### hdl/vah_pkg.sv
// Shared constants, types and arctangent table for the vector angle to hue colour block.
package vah_pkg;

    localparam int GUARD_BITS   = 8;
    localparam int TABLE_LEN    = 24;
    localparam int Z_BITS       = 34;
    localparam int LEVEL_BITS   = 8;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_LEVEL = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_LEVEL = 1'b1;

    localparam logic [LEVEL_BITS-1:0] MAX_LEVEL_RST = 8'd255;
    localparam logic [LEVEL_BITS-1:0] MIN_LEVEL_RST = 8'd50;

    localparam logic signed [Z_BITS-1:0] HALF_TURN = 34'sh0_8000_0000;

    localparam logic [31:0] ATAN_TURN [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic skip;
        logic zero;
    } t_flags;

    typedef enum logic [2:0] {
        SEC_G_UP  = 3'd0,
        SEC_R_DN  = 3'd1,
        SEC_B_UP  = 3'd2,
        SEC_B_UPN = 3'd3,
        SEC_R_DNN = 3'd4,
        SEC_G_UPN = 3'd5
    } t_sector;

endpackage

### hdl/vah_vec_if.sv
// Handshake channel carrying one input vector word.
interface vah_vec_if #(
    parameter int COORD_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vec_x;
    logic signed [COORD_BITS-1:0] vec_y;

    modport source (output valid, vec_x, vec_y, input ready);
    modport sink   (input valid, vec_x, vec_y, output ready);
endinterface

### hdl/vah_rgb_if.sv
// Handshake channel carrying one RGB colour word.
interface vah_rgb_if ();
    logic                            valid;
    logic                            ready;
    logic [vah_pkg::LEVEL_BITS-1:0]  red;
    logic [vah_pkg::LEVEL_BITS-1:0]  green;
    logic [vah_pkg::LEVEL_BITS-1:0]  blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

### hdl/vah_cordic_cell.sv
// One CORDIC vectoring cell: a single micro-rotation with its output register.
module vah_cordic_cell #(
    parameter int XW    = 27,
    parameter int SHIFT = 0
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [XW-1:0]              i_x,
    input  logic signed [XW-1:0]              i_y,
    input  logic signed [vah_pkg::Z_BITS-1:0] i_z,
    input  vah_pkg::t_flags                   i_flags,
    output logic signed [XW-1:0]              o_x,
    output logic signed [XW-1:0]              o_y,
    output logic signed [vah_pkg::Z_BITS-1:0] o_z,
    output vah_pkg::t_flags                   o_flags
);
    import vah_pkg::*;

    localparam logic signed [Z_BITS-1:0] STEP_ANGLE =
        {{(Z_BITS-32){1'b0}}, ATAN_TURN[SHIFT]};

    logic signed [XW-1:0]     w_dx;
    logic signed [XW-1:0]     w_dy;
    logic signed [XW-1:0]     n_x;
    logic signed [XW-1:0]     n_y;
    logic signed [Z_BITS-1:0] n_z;
    logic signed [XW-1:0]     r_x;
    logic signed [XW-1:0]     r_y;
    logic signed [Z_BITS-1:0] r_z;
    t_flags                   r_flags;

    assign w_dx = i_y >>> SHIFT;
    assign w_dy = i_x >>> SHIFT;

    always_comb begin
        if (i_flags.skip) begin
            n_x = i_x;
            n_y = i_y;
            n_z = i_z;
        end else if (!i_y[XW-1]) begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + STEP_ANGLE;
        end else begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - STEP_ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_z     <= n_z;
            r_flags <= i_flags;
        end
    end

    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_flags = r_flags;
endmodule

### hdl/vah_hue_map.sv
// Angle to hue wheel mapping: angle units, sector decode and channel ramp, three stages.
module vah_hue_map #(
    parameter int SECTOR_FRACTION_BITS = 12
) (
    input  logic                              i_clk,
    input  logic [2:0]                        i_load,
    input  logic signed [vah_pkg::Z_BITS-1:0] i_z,
    input  logic                              i_zero,
    input  logic [vah_pkg::LEVEL_BITS-1:0]    i_max_level,
    input  logic [vah_pkg::LEVEL_BITS-1:0]    i_min_level,
    output logic [vah_pkg::LEVEL_BITS-1:0]    o_red,
    output logic [vah_pkg::LEVEL_BITS-1:0]    o_green,
    output logic [vah_pkg::LEVEL_BITS-1:0]    o_blue
);
    import vah_pkg::*;

    localparam int F  = SECTOR_FRACTION_BITS;
    localparam int S  = 1 << F;
    localparam int AW = F + 4;
    localparam int FW = F + 1;
    localparam int PW = Z_BITS + F + 3;
    localparam int MW = LEVEL_BITS + FW;

    localparam logic signed [PW-1:0] ROUND_HALF = {{(PW-32){1'b0}}, 32'h8000_0000};
    localparam logic signed [AW-1:0] A_S  = AW'(S);
    localparam logic signed [AW-1:0] A_2S = AW'(2 * S);
    localparam logic signed [AW-1:0] A_3S = AW'(3 * S);
    localparam logic signed [AW-1:0] A_6S = AW'(6 * S);

    logic signed [PW-1:0]   w_zx;
    logic signed [PW-1:0]   w_prod;
    logic signed [AW-1:0]   w_a;
    logic signed [AW-1:0]   n_a;
    logic signed [AW-1:0]   r_a;
    logic                   r_zero_a;

    logic signed [AW-1:0]   w_off;
    t_sector                n_sec;
    t_sector                r_sec;
    logic [FW-1:0]          r_f;
    logic                   r_zero_b;

    logic [LEVEL_BITS-1:0]  w_range;
    logic [MW-1:0]          w_mul;
    logic [LEVEL_BITS-1:0]  w_p;
    logic [LEVEL_BITS-1:0]  w_up;
    logic [LEVEL_BITS-1:0]  w_dn;
    logic [LEVEL_BITS-1:0]  n_red;
    logic [LEVEL_BITS-1:0]  n_green;
    logic [LEVEL_BITS-1:0]  n_blue;
    logic [LEVEL_BITS-1:0]  r_red;
    logic [LEVEL_BITS-1:0]  r_green;
    logic [LEVEL_BITS-1:0]  r_blue;

    // angle in sector units, rounded half up, folded into (-3S, 3S]
    assign w_zx   = PW'(i_z);
    assign w_prod = ((w_zx + (w_zx <<< 1)) <<< (F + 1)) + ROUND_HALF;
    assign w_a    = w_prod[32 +: AW];

    always_comb begin
        if (w_a > A_3S) begin
            n_a = w_a - A_6S;
        end else if (w_a <= -A_3S) begin
            n_a = w_a + A_6S;
        end else begin
            n_a = w_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_a      <= n_a;
            r_zero_a <= i_zero;
        end
    end

    always_comb begin
        if (!r_a[AW-1] && r_a <= A_S) begin
            n_sec = SEC_G_UP;
            w_off = r_a;
        end else if (!r_a[AW-1] && r_a <= A_2S) begin
            n_sec = SEC_R_DN;
            w_off = r_a - A_S;
        end else if (!r_a[AW-1]) begin
            n_sec = SEC_B_UP;
            w_off = r_a - A_2S;
        end else if (r_a > -A_S) begin
            n_sec = SEC_B_UPN;
            w_off = -r_a;
        end else if (r_a > -A_2S) begin
            n_sec = SEC_R_DNN;
            w_off = -r_a - A_S;
        end else begin
            n_sec = SEC_G_UPN;
            w_off = -r_a - A_2S;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r_sec    <= n_sec;
            r_f      <= w_off[FW-1:0];
            r_zero_b <= r_zero_a;
        end
    end

    assign w_range = (i_max_level > i_min_level) ? (i_max_level - i_min_level) : '0;
    assign w_mul   = MW'(w_range) * MW'(r_f);
    assign w_p     = w_mul[F +: LEVEL_BITS];
    assign w_up    = i_min_level + w_p;
    assign w_dn    = i_max_level - w_p;

    always_comb begin
        case (r_sec)
            SEC_G_UP: begin
                n_red = i_max_level; n_green = w_up;        n_blue = i_min_level;
            end
            SEC_R_DN: begin
                n_red = w_dn;        n_green = i_max_level; n_blue = i_min_level;
            end
            SEC_B_UP: begin
                n_red = i_min_level; n_green = i_max_level; n_blue = w_up;
            end
            SEC_B_UPN: begin
                n_red = i_max_level; n_green = i_min_level; n_blue = w_up;
            end
            SEC_R_DNN: begin
                n_red = w_dn;        n_green = i_min_level; n_blue = i_max_level;
            end
            default: begin
                n_red = i_min_level; n_green = w_up;        n_blue = i_max_level;
            end
        endcase
        if (r_zero_b) begin
            n_red   = i_min_level;
            n_green = i_max_level;
            n_blue  = i_max_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
endmodule

### hdl/vector_angle_to_hue_colour_top.sv
// Top level: vector to hue wheel colour through a chain of CORDIC cells.
// An accepted word passes the entry register, the CORDIC cell registers and the hue map registers in turn.
// Throughput: one word per cycle while o_rgb.ready is high; each cell hands its word on whenever its stage advances.
// Stalls free each stage once its successor moves, so bubbles close up.
// Reset (i_rst_n low, synchronous) empties the chain, sets max_level to 255
// and min_level to 50.
module vector_angle_to_hue_colour_top #(
    parameter int COORD_BITS           = 16,
    parameter int CORDIC_STEPS         = 16,
    parameter int SECTOR_FRACTION_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    vah_vec_if.sink                             i_vec,
    vah_rgb_if.source                           o_rgb,
    input  logic                                i_cfg_we,
    input  logic [vah_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [vah_pkg::LEVEL_BITS-1:0]      i_cfg_data
);
    import vah_pkg::*;

    localparam int XW = COORD_BITS + GUARD_BITS + 3;
    localparam int NS = CORDIC_STEPS + 4;

    logic [LEVEL_BITS-1:0] r_max_level;
    logic [LEVEL_BITS-1:0] r_min_level;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS:0]   w_rdy;

    logic signed [XW-1:0]     w_xe;
    logic signed [XW-1:0]     w_ye;
    logic                     w_x_neg;
    logic                     w_x_zero;
    logic                     w_y_zero;
    logic signed [XW-1:0]     n_x0;
    logic signed [XW-1:0]     n_y0;
    logic signed [Z_BITS-1:0] n_z0;
    t_flags                   n_fl0;
    logic signed [XW-1:0]     r_x0;
    logic signed [XW-1:0]     r_y0;
    logic signed [Z_BITS-1:0] r_z0;
    t_flags                   r_fl0;

    logic signed [XW-1:0]     w_x  [CORDIC_STEPS+1];
    logic signed [XW-1:0]     w_y  [CORDIC_STEPS+1];
    logic signed [Z_BITS-1:0] w_z  [CORDIC_STEPS+1];
    t_flags                   w_fl [CORDIC_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_level <= MAX_LEVEL_RST;
            r_min_level <= MIN_LEVEL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_LEVEL: r_max_level <= i_cfg_data;
                CFG_MIN_LEVEL: r_min_level <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage advances when empty or when its successor advances
    assign w_rdy[NS] = o_rgb.ready;
    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_rdy
            assign w_rdy[g] = !r_vld[g] || w_rdy[g+1];
        end
    endgenerate

    assign n_vld = {r_vld[NS-2:0], i_vec.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (w_rdy[s]) begin
                    r_vld[s] <= n_vld[s];
                end
            end
        end
    end

    assign i_vec.ready = w_rdy[0];

    // entry: fold into right half plane, seed the angle, add guard bits
    assign w_xe     = XW'(i_vec.vec_x);
    assign w_ye     = XW'(i_vec.vec_y);
    assign w_x_neg  = i_vec.vec_x[COORD_BITS-1];
    assign w_x_zero = (i_vec.vec_x == '0);
    assign w_y_zero = (i_vec.vec_y == '0);

    always_comb begin
        n_fl0.skip = w_y_zero;
        n_fl0.zero = w_y_zero && w_x_zero;
        n_x0       = w_xe <<< GUARD_BITS;
        n_y0       = w_ye <<< GUARD_BITS;
        if (w_y_zero) begin
            n_z0 = (!w_x_neg && !w_x_zero) ? '0 : HALF_TURN;
        end else if (w_x_neg) begin
            n_z0 = i_vec.vec_y[COORD_BITS-1] ? -HALF_TURN : HALF_TURN;
            n_x0 = (-w_xe) <<< GUARD_BITS;
            n_y0 = (-w_ye) <<< GUARD_BITS;
        end else begin
            n_z0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_x0  <= n_x0;
            r_y0  <= n_y0;
            r_z0  <= n_z0;
            r_fl0 <= n_fl0;
        end
    end

    assign w_x[0]  = r_x0;
    assign w_y[0]  = r_y0;
    assign w_z[0]  = r_z0;
    assign w_fl[0] = r_fl0;

    generate
        for (g = 0; g < CORDIC_STEPS; g++) begin : g_cell
            vah_cordic_cell #(
                .XW    (XW),
                .SHIFT (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_en    (w_rdy[g+1]),
                .i_x     (w_x[g]),
                .i_y     (w_y[g]),
                .i_z     (w_z[g]),
                .i_flags (w_fl[g]),
                .o_x     (w_x[g+1]),
                .o_y     (w_y[g+1]),
                .o_z     (w_z[g+1]),
                .o_flags (w_fl[g+1])
            );
        end
    endgenerate

    vah_hue_map #(
        .SECTOR_FRACTION_BITS (SECTOR_FRACTION_BITS)
    ) u_hue_map (
        .i_clk       (i_clk),
        .i_load      (w_rdy[NS-1:NS-3]),
        .i_z         (w_z[CORDIC_STEPS]),
        .i_zero      (w_fl[CORDIC_STEPS].zero),
        .i_max_level (r_max_level),
        .i_min_level (r_min_level),
        .o_red       (o_rgb.red),
        .o_green     (o_rgb.green),
        .o_blue      (o_rgb.blue)
    );

    assign o_rgb.valid = r_vld[NS-1];
endmodule
